/* sv/tspr_pkg.sv */
package tspr_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;
   localparam int REQ_DATA_W  = 56;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 24;

   typedef enum logic [1:0] {
      MODE_STATUS_RD = 2'd0,
      MODE_STATUS_WR = 2'd1,
      MODE_DATA_RD   = 2'd2,
      MODE_DATA_WR   = 2'd3
   } mode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REVISION     = 3'd0,
      CSR_UPPER_CASE   = 3'd1,
      CSR_STRIP_PARITY = 3'd2,
      CSR_DROP_NULLS   = 3'd3,
      CSR_CHAR_TIME    = 3'd4
   } csr_index_type;

   localparam logic [19:0] CHAR_TIME_RESET = 20'd86;
   localparam logic [7:0]  REV1_BASE       = 8'h81;
   localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
   localparam logic [7:0]  CHAR_LOWER_Z    = 8'h7a;

   typedef struct packed {
      logic        revision;
      logic        upper_case;
      logic        strip_parity;
      logic        drop_nulls;
      logic [19:0] char_time_us;
   } cfg_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  write_data;
      logic [31:0] now_us;
      logic        rx_ready;
      logic [7:0]  rx_byte;
   } item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       rx_taken;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } result_type;

endpackage

/* sv/terminal_serial_port_regs.sv */
// a req transaction passes the input register and then the result register before
//   it is offered as an rsp transaction
// throughput: one transaction per cycle while rsp_tready does not hold the result register;
//   the access stage reads and writes the pacing time and last byte in the same cycle
// reset (synchronous, active high) empties both registers, restores the control
//   registers to their defaults and clears the last byte and last transfer time
module terminal_serial_port_regs (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // from bit 0: write_data[7:0], now_us[31:0], rx_ready, rx_byte[7:0], zero pad
   input  logic [tspr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // from bit 0: mode[1:0]
   input  logic [tspr_pkg::REQ_USER_W-1:0]    req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // from bit 0: read_data[7:0], rx_taken, tx_valid, tx_byte[7:0], zero pad
   output logic [tspr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // control register write channel
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tspr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [tspr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import tspr_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   result_type res_ff, res_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;
   logic       req_fire;

   // register writes are taken at once
   assign csr_ready = 1'b1;

   tspr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // access stage moves forward when the result register is free or draining
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;

   // unpack the request transaction
   always_comb begin
      item_in            = item_ff;
      if (req_fire) begin
         item_in.mode       = mode_type'(req_tuser);
         item_in.write_data = req_tdata[7:0];
         item_in.now_us     = req_tdata[39:8];
         item_in.rx_ready   = req_tdata[40];
         item_in.rx_byte    = req_tdata[48:41];
      end
   end

   assign in_valid_in = req_fire || (in_valid_ff && !advance);

   tspr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (res_in)
   );

   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (advance) res_ff <= res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, res_ff.tx_byte, res_ff.tx_valid, res_ff.rx_taken,
                        res_ff.read_data};

`ifndef SYNTHESIS
   // a write never returns read data
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res_ff.tx_valid |-> res_ff.read_data == 8'h00)
      else $error("read data on a transmit result");

   // one result can not both consume and send
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(res_ff.rx_taken && res_ff.tx_valid))
      else $error("consume and send in one result");

   // an empty result register never blocks the request side
   assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> req_tready)
      else $error("request stalled with empty result register");

   // results come only from accepted requests
   assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(in_valid_ff))
      else $error("result without a request");
`endif

endmodule

/* sv/tspr_csr.sv */
module tspr_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [tspr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tspr_pkg::CSR_DATA_W-1:0]     csr_data,
   output tspr_pkg::cfg_type                   cfg
);
   import tspr_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_REVISION:     cfg_in.revision     = csr_data[0];
            CSR_UPPER_CASE:   cfg_in.upper_case   = csr_data[0];
            CSR_STRIP_PARITY: cfg_in.strip_parity = csr_data[0];
            CSR_DROP_NULLS:   cfg_in.drop_nulls   = csr_data[0];
            CSR_CHAR_TIME:    cfg_in.char_time_us = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.revision     <= 1'b0;
         cfg_ff.upper_case   <= 1'b0;
         cfg_ff.strip_parity <= 1'b0;
         cfg_ff.drop_nulls   <= 1'b0;
         cfg_ff.char_time_us <= CHAR_TIME_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/tspr_core.sv */
module tspr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  tspr_pkg::item_type    item,
   input  tspr_pkg::cfg_type     cfg,
   output tspr_pkg::result_type  result
);
   import tspr_pkg::*;

   logic [7:0]  last_rx_ff,   last_rx_in;
   logic [31:0] last_time_ff, last_time_in;

   logic [31:0] elapsed;
   logic        in_window;
   logic [7:0]  status_byte;
   logic        status_touch;
   logic [7:0]  rx_char;
   logic        send;
   logic [7:0]  tx_char;

   // pacing window: nonzero character time and wrapped elapsed time below one character time
   assign elapsed   = item.now_us - last_time_ff;
   assign in_window = (cfg.char_time_us != '0) && (elapsed < {12'd0, cfg.char_time_us});

   always_comb begin
      status_touch = !in_window;
      if (in_window) begin
         status_byte = cfg.revision ? REV1_BASE : 8'h00;
      end else if (cfg.revision) begin
         status_byte = {7'd0, !item.rx_ready};
      end else begin
         status_byte = {2'b00, item.rx_ready, 3'b000, 1'b1, 1'b0};
      end
   end

   always_comb begin
      rx_char = item.rx_byte;
      if (cfg.upper_case && item.rx_byte >= CHAR_LOWER_A && item.rx_byte <= CHAR_LOWER_Z) begin
         rx_char = {item.rx_byte[7:6], 1'b0, item.rx_byte[4:0]};
      end
   end

   assign send    = !(cfg.drop_nulls && item.write_data == 8'h00);
   assign tx_char = {item.write_data[7] & !cfg.strip_parity, item.write_data[6:0]};

   always_comb begin
      result       = '0;
      last_rx_in   = last_rx_ff;
      last_time_in = last_time_ff;
      case (item.mode)
         MODE_STATUS_RD: begin
            result.read_data = status_byte;
            if (status_touch) last_time_in = item.now_us;
         end
         MODE_DATA_RD: begin
            if (item.rx_ready) begin
               last_rx_in      = rx_char;
               last_time_in    = item.now_us;
               result.rx_taken = 1'b1;
               result.read_data = rx_char;
            end else begin
               result.read_data = last_rx_ff;
            end
         end
         MODE_DATA_WR: begin
            if (send) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = tx_char;
               last_time_in    = item.now_us;
            end
         end
         default: result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_rx_ff   <= '0;
         last_time_ff <= '0;
      end else if (fire) begin
         last_rx_ff   <= last_rx_in;
         last_time_ff <= last_time_in;
      end
   end

endmodule
